// ----- hw/rtl/mpq_pkg.sv -----
`default_nettype none
package mpq_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE_MIN = 1'b1;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_REMOVED = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    localparam logic REG_UNIQUE_MODE = 1'b0;

    typedef struct packed {
        logic        command;
        logic [31:0] key;
        logic [31:0] payload;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_payload;
    } result_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] payload;
    } entry_t;

endpackage
`default_nettype wire

// ----- hw/rtl/min_priority_queue.sv -----
`default_nettype none
// Channel   Handshake                Word
// request   start in, busy out       request  (command, key, payload)
// result    done out (one cycle)     result   (status, out_payload)
// config    APB psel/penable/pwrite  paddr, pwdata, prdata; pready tied high
//
// Entries sit sorted by key in a single-port-write, registered-read memory.
// Insert: linear key search, then one shift step per moved entry, each a read then a
// write. Delete-min: a head read, then one shift step per remaining entry, each a read
// then a write. An empty delete touches no memory; a replace or a full drop ends without a shift.
// Reset clears the entry count and the mode register; memory contents are not cleared.
// busy rises after the accepting edge and falls as done pulses; an empty delete leaves
// busy low. done cannot be stalled.
module min_priority_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire mpq_pkg::request_t request,
    output logic                   done,
    output mpq_pkg::result_t       result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_CNT = CW'(1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SRCH_RD  = 3'd1;
    localparam logic [2:0] S_SRCH_CMP = 3'd2;
    localparam logic [2:0] S_SH_RD    = 3'd3;
    localparam logic [2:0] S_SH_WR    = 3'd4;
    localparam logic [2:0] S_DEL_HEAD = 3'd5;
    localparam logic [2:0] S_DL_RD    = 3'd6;
    localparam logic [2:0] S_DL_WR    = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic [31:0]            key_reg, key_next;
    logic [31:0]            pay_reg, pay_next;
    logic                   cmd_reg, cmd_next;
    logic                   unique_reg;
    logic                   done_reg, done_next;
    logic [2:0]             status_reg, status_next;
    logic [31:0]            opay_reg, opay_next;

    mpq_pkg::entry_t        mem [QUEUE_DEPTH];
    mpq_pkg::entry_t        rd_data_reg;
    mpq_pkg::entry_t        wr_data;
    logic                   rd_en, wr_en;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic [CW-1:0]          ptr_dec;
    logic                   cfg_wr;

    assign ptr_dec = ptr_reg - ONE_CNT;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        ptr_next    = ptr_reg;
        key_next    = key_reg;
        pay_next    = pay_reg;
        cmd_next    = cmd_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        opay_next   = opay_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = rd_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = request.command;
                    key_next = request.key;
                    pay_next = request.payload;
                    if (request.command == mpq_pkg::CMD_INSERT)
                    begin
                        idx_next   = '0;
                        state_next = S_SRCH_RD;
                    end
                    else if (cnt_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = mpq_pkg::ST_EMPTY;
                        opay_next   = '0;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_DEL_HEAD;
                    end
                end
            end
            S_SRCH_RD:
            begin
                if (idx_reg < cnt_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg[AW-1:0];
                    state_next = S_SRCH_CMP;
                end
                else if (cnt_reg == DEPTH_CNT)
                begin
                    done_next   = 1'b1;
                    status_next = mpq_pkg::ST_FULL;
                    opay_next   = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ptr_next   = cnt_reg;
                    state_next = S_SH_RD;
                end
            end
            S_SRCH_CMP:
            begin
                if (rd_data_reg.key < key_reg)
                begin
                    idx_next   = idx_reg + ONE_CNT;
                    state_next = S_SRCH_RD;
                end
                else if (unique_reg && (rd_data_reg.key == key_reg))
                begin
                    wr_en       = 1'b1;
                    wr_addr     = idx_reg[AW-1:0];
                    wr_data     = '{key: key_reg, payload: pay_reg};
                    done_next   = 1'b1;
                    status_next = mpq_pkg::ST_REPLACED;
                    opay_next   = '0;
                    state_next  = S_IDLE;
                end
                else if (cnt_reg == DEPTH_CNT)
                begin
                    done_next   = 1'b1;
                    status_next = mpq_pkg::ST_FULL;
                    opay_next   = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ptr_next   = cnt_reg;
                    state_next = S_SH_RD;
                end
            end
            S_SH_RD:
            begin
                if (ptr_reg > idx_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_dec[AW-1:0];
                    state_next = S_SH_WR;
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_addr     = idx_reg[AW-1:0];
                    wr_data     = '{key: key_reg, payload: pay_reg};
                    cnt_next    = cnt_reg + ONE_CNT;
                    done_next   = 1'b1;
                    status_next = mpq_pkg::ST_INSERTED;
                    opay_next   = '0;
                    state_next  = S_IDLE;
                end
            end
            S_SH_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg[AW-1:0];
                ptr_next   = ptr_dec;
                state_next = S_SH_RD;
            end
            S_DEL_HEAD:
            begin
                opay_next  = rd_data_reg.payload;
                ptr_next   = ONE_CNT;
                state_next = S_DL_RD;
            end
            S_DL_RD:
            begin
                if (ptr_reg < cnt_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_reg[AW-1:0];
                    state_next = S_DL_WR;
                end
                else
                begin
                    cnt_next    = cnt_reg - ONE_CNT;
                    done_next   = 1'b1;
                    status_next = mpq_pkg::ST_REMOVED;
                    state_next  = S_IDLE;
                end
            end
            S_DL_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_dec[AW-1:0];
                ptr_next   = ptr_reg + ONE_CNT;
                state_next = S_DL_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            unique_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (cfg_wr && (paddr[2] == mpq_pkg::REG_UNIQUE_MODE))
            begin
                unique_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        ptr_reg    <= ptr_next;
        key_reg    <= key_next;
        pay_reg    <= pay_next;
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        opay_reg   <= opay_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = '{status: status_reg,
                      out_payload: (cmd_reg == mpq_pkg::CMD_DELETE_MIN) ? opay_reg : 32'd0};
    assign pready = 1'b1;
    assign prdata = (paddr[2] == mpq_pkg::REG_UNIQUE_MODE)
                    ? {31'd0, unique_reg} : 32'd0;

endmodule
`default_nettype wire
